### rtl/core/fixed_partition_best_fit_allocator_macros.svh
// Assertion macros shared by the checker of the partition allocator.
// Relies on i_clk and i_rst_n being visible where a macro is used.
`ifndef FIXED_PARTITION_BEST_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_BEST_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication, muted during reset
`define FPBF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, muted during reset
`define FPBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/core/fpbf_pkg.sv
// Shared types and constants of the fixed-partition best-fit allocator.
// No dependencies.
`default_nettype none

package fpbf_pkg;

    localparam int NUM_PART    = 16;
    localparam int PART_IDX_W  = 4;
    localparam int PART_CNT_W  = 5;
    localparam int NUM_PROC    = 256;
    localparam int PROC_ADDR_W = 8;
    localparam int PID_W       = 9;
    localparam int SIZE_W      = 16;
    localparam int STATUS_W    = 4;

    typedef enum logic [1:0] {
        OP_DEFINE = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DEFINED    = 4'd0,
        ST_TOO_BIG    = 4'd1,
        ST_PLACED     = 4'd2,
        ST_INT_FRAG   = 4'd3,
        ST_EXT_FRAG   = 4'd4,
        ST_NO_FIT     = 4'd5,
        ST_FREED      = 4'd6,
        ST_NOT_PLACED = 4'd7,
        ST_UNKNOWN_ID = 4'd8,
        ST_TABLE_FULL = 4'd9
    } t_status;

    typedef struct packed {
        logic load;
        logic idx_clr;
        logic scan;
        logic frag;
        logic def_go;
        logic alloc_full;
        logic place;
        logic no_fit;
        logic unknown;
        logic free_idx;
        logic free_go;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic proc_full;
        logic pid_bad;
        logic found;
        logic scan_last;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/fixed_partition_best_fit_allocator.sv
// Fixed-partition best-fit allocator, top level.
// Depends on fpbf_pkg, fpbf_ctrl and fpbf_dp.
//
// One word at a time. An allocate steps through all 16 partition entries in the
// best-fit search, one per cycle, and when nothing fits it steps through them all
// again in the fragmentation check. Results wait in an output register; a new
// word is taken once the previous one has reached it. Configuration writes are
// taken every cycle and recompute the registered unused total.
`default_nettype none

module fixed_partition_best_fit_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fpbf_pkg::SIZE_W-1:0]     i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [1:0]                      i_op,
    input  wire logic [fpbf_pkg::SIZE_W-1:0]     i_size_kb,
    input  wire logic [fpbf_pkg::PID_W-1:0]      i_process_id,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [fpbf_pkg::STATUS_W-1:0]   o_status,
    output logic      [fpbf_pkg::PID_W-1:0]      o_process_id_res,
    output logic      [fpbf_pkg::PART_CNT_W-1:0] o_partition_number,
    output logic      [fpbf_pkg::SIZE_W-1:0]     o_leftover_kb,
    output logic      [fpbf_pkg::SIZE_W-1:0]     o_fragmentation_total_kb,
    output logic      [fpbf_pkg::SIZE_W-1:0]     o_unused_kb
);
    import fpbf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    fpbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fpbf_dp u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (cmd),
        .o_stat                   (stat),
        .i_cfg_valid              (i_cfg_valid),
        .i_cfg_data               (i_cfg_data),
        .i_op                     (i_op),
        .i_size_kb                (i_size_kb),
        .i_process_id             (i_process_id),
        .o_status                 (o_status),
        .o_process_id_res         (o_process_id_res),
        .o_partition_number       (o_partition_number),
        .o_leftover_kb            (o_leftover_kb),
        .o_fragmentation_total_kb (o_fragmentation_total_kb),
        .o_unused_kb              (o_unused_kb)
    );

endmodule

`default_nettype wire

### rtl/core/fpbf_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none

module fpbf_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/fpbf_ctrl.sv
// Sequencer of the partition allocator: walks each operation through its steps.
// Depends on fpbf_pkg.
`default_nettype none

module fpbf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire fpbf_pkg::t_dp_stat i_stat,
    output fpbf_pkg::t_dp_cmd      o_cmd
);
    import fpbf_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DECODE   = 13'b0000000000010,
        S_DEF      = 13'b0000000000100,
        S_FULL     = 13'b0000000001000,
        S_SCAN     = 13'b0000000010000,
        S_FRAG     = 13'b0000000100000,
        S_PLACE    = 13'b0000001000000,
        S_NOFIT    = 13'b0000010000000,
        S_UNK      = 13'b0000100000000,
        S_FREE_IDX = 13'b0001000000000,
        S_FREE     = 13'b0010000000000,
        S_OUT      = 13'b0100000000000,
        S_SPARE    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.idx_clr = 1'b1;
                case (i_stat.op)
                    OP_DEFINE: n_state = S_DEF;
                    OP_ALLOC:  n_state = i_stat.proc_full ? S_FULL : S_SCAN;
                    OP_FREE:   n_state = i_stat.pid_bad ? S_UNK : S_FREE_IDX;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_DEF: begin
                o_cmd.def_go = 1'b1;
                n_state      = S_OUT;
            end
            S_FULL: begin
                o_cmd.alloc_full = 1'b1;
                n_state          = S_OUT;
            end
            S_SCAN: begin
                // index wraps to zero on the last entry, ready for the second pass
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = i_stat.found ? S_PLACE : S_FRAG;
                end
            end
            S_FRAG: begin
                o_cmd.frag = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_NOFIT;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_OUT;
            end
            S_NOFIT: begin
                o_cmd.no_fit = 1'b1;
                n_state      = S_OUT;
            end
            S_UNK: begin
                o_cmd.unknown = 1'b1;
                n_state       = S_OUT;
            end
            S_FREE_IDX: begin
                o_cmd.free_idx = 1'b1;
                n_state        = S_FREE;
            end
            S_FREE: begin
                o_cmd.free_go = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/core/fpbf_dp.sv
// Datapath of the partition allocator: partition table, counters, result registers.
// Depends on fpbf_pkg and fpbf_ram.
`default_nettype none

module fpbf_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fpbf_pkg::t_dp_cmd               i_cmd,
    output fpbf_pkg::t_dp_stat                   o_stat,
    input  wire logic                            i_cfg_valid,
    input  wire logic [fpbf_pkg::SIZE_W-1:0]     i_cfg_data,
    input  wire logic [1:0]                      i_op,
    input  wire logic [fpbf_pkg::SIZE_W-1:0]     i_size_kb,
    input  wire logic [fpbf_pkg::PID_W-1:0]      i_process_id,
    output logic      [fpbf_pkg::STATUS_W-1:0]   o_status,
    output logic      [fpbf_pkg::PID_W-1:0]      o_process_id_res,
    output logic      [fpbf_pkg::PART_CNT_W-1:0] o_partition_number,
    output logic      [fpbf_pkg::SIZE_W-1:0]     o_leftover_kb,
    output logic      [fpbf_pkg::SIZE_W-1:0]     o_fragmentation_total_kb,
    output logic      [fpbf_pkg::SIZE_W-1:0]     o_unused_kb
);
    import fpbf_pkg::*;

    // latched word
    t_op                    r_op;
    logic [SIZE_W-1:0]      r_req;
    logic [PID_W-1:0]       r_pid;

    // partition table
    logic [SIZE_W-1:0]      r_size [NUM_PART];
    logic [NUM_PART-1:0]    r_usable;
    logic [NUM_PART-1:0]    r_busy;
    logic [SIZE_W-1:0]      r_left [NUM_PART];
    logic [PART_CNT_W-1:0]  r_count;

    logic [SIZE_W-1:0]      r_remain, r_used, r_frag;
    logic [PID_W-1:0]       r_pcount;

    // search state
    logic [PART_IDX_W-1:0]  r_idx;
    logic                   r_found, r_int;
    logic [PART_IDX_W-1:0]  r_best;
    logic [SIZE_W-1:0]      r_best_left;
    logic [PART_CNT_W-1:0]  r_home;

    // staged result and output register
    t_status                r_res_status;
    logic [PID_W-1:0]       r_res_pid;
    logic [PART_CNT_W-1:0]  r_res_pn;
    logic [SIZE_W-1:0]      r_res_left, r_res_frag, r_res_unused;
    t_status                r_o_status;
    logic [PID_W-1:0]       r_o_pid;
    logic [PART_CNT_W-1:0]  r_o_pn;
    logic [SIZE_W-1:0]      r_o_left, r_o_frag, r_o_unused;

    logic [SIZE_W-1:0]      sz, lo, cand_left, frag_add, frag_sub;
    logic                   elig, beats;
    logic [PID_W-1:0]       pid_m1, pcount_p1;
    logic [PART_IDX_W-1:0]  new_k;
    logic                   ram_we;
    logic [PROC_ADDR_W-1:0] ram_waddr;
    logic [PART_CNT_W-1:0]  ram_wdata, ram_rdata;

    assign sz        = r_size[r_idx];
    assign lo        = r_left[r_idx];
    assign elig      = r_usable[r_idx] && !r_busy[r_idx] && (r_req <= sz);
    assign cand_left = sz - r_req;
    assign beats     = elig && (!r_found || (cand_left < r_best_left));
    assign frag_add  = r_frag + r_best_left;
    assign frag_sub  = (r_frag >= lo) ? (r_frag - lo) : '0;
    assign pid_m1    = r_pid - PID_W'(1);
    assign pcount_p1 = r_pcount + PID_W'(1);
    assign new_k     = r_count[PART_IDX_W-1:0];

    assign o_stat.op        = r_op;
    assign o_stat.proc_full = (r_pcount == PID_W'(NUM_PROC));
    assign o_stat.pid_bad   = (r_pid == '0) || (r_pid > r_pcount);
    assign o_stat.found     = r_found || elig;
    assign o_stat.scan_last = (r_idx == PART_IDX_W'(NUM_PART - 1));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pcount[PROC_ADDR_W-1:0];
        ram_wdata = '0;
        if (i_cmd.place) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b0, r_best} + PART_CNT_W'(1);
        end else if (i_cmd.no_fit) begin
            ram_we    = 1'b1;
        end else if (i_cmd.free_go) begin
            ram_we    = 1'b1;
            ram_waddr = pid_m1[PROC_ADDR_W-1:0];
        end
    end

    // home partition of each process number, entry n for number n+1
    fpbf_ram #(
        .WIDTH (PART_CNT_W),
        .DEPTH (NUM_PROC)
    ) u_home (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (pid_m1[PROC_ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // control and reset-valued state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable <= '0;
            r_busy   <= '0;
            for (int i = 0; i < NUM_PART; i++) begin
                r_left[i] <= '0;
            end
            r_count  <= '0;
            r_remain <= '1;
            r_used   <= '0;
            r_frag   <= '0;
            r_pcount <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_remain <= (r_used >= i_cfg_data) ? '0 : (i_cfg_data - r_used);
            end
            if (i_cmd.def_go && (r_count != PART_CNT_W'(NUM_PART))) begin
                r_busy[new_k] <= 1'b0;
                r_left[new_k] <= '0;
                r_count       <= r_count + PART_CNT_W'(1);
                if (r_req <= r_remain) begin
                    r_usable[new_k] <= 1'b1;
                    r_remain        <= r_remain - r_req;
                    r_used          <= r_used + r_req;
                end else begin
                    r_usable[new_k] <= 1'b0;
                end
            end
            if (i_cmd.place) begin
                r_busy[r_best] <= 1'b1;
                r_left[r_best] <= r_best_left;
                r_frag         <= frag_add;
                r_pcount       <= pcount_p1;
            end
            if (i_cmd.no_fit) begin
                r_pcount <= pcount_p1;
            end
            if (i_cmd.free_go && (r_home != '0) && r_busy[r_idx]) begin
                r_busy[r_idx] <= 1'b0;
                r_frag        <= frag_sub;
            end
        end
    end

    // payload and search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_op);
            r_req <= i_size_kb;
            r_pid <= i_process_id;
        end
        if (i_cmd.def_go && (r_count != PART_CNT_W'(NUM_PART))) begin
            r_size[new_k] <= r_req;
        end
        if (i_cmd.idx_clr) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_int   <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + PART_IDX_W'(1);
            if (beats) begin
                r_found     <= 1'b1;
                r_best      <= r_idx;
                r_best_left <= cand_left;
            end
        end
        if (i_cmd.frag) begin
            r_idx <= r_idx + PART_IDX_W'(1);
            if (r_usable[r_idx] && r_busy[r_idx] && (lo >= r_req)) begin
                r_int <= 1'b1;
            end
        end
        if (i_cmd.free_idx) begin
            r_home <= ram_rdata;
            r_idx  <= ram_rdata[PART_IDX_W-1:0] - PART_IDX_W'(1);
        end

        if (i_cmd.def_go) begin
            r_res_pid  <= '0;
            r_res_left <= '0;
            r_res_frag <= r_frag;
            if (r_count == PART_CNT_W'(NUM_PART)) begin
                r_res_status <= ST_TABLE_FULL;
                r_res_pn     <= '0;
                r_res_unused <= r_remain;
            end else begin
                r_res_pn <= r_count + PART_CNT_W'(1);
                if (r_req <= r_remain) begin
                    r_res_status <= ST_DEFINED;
                    r_res_unused <= r_remain - r_req;
                end else begin
                    r_res_status <= ST_TOO_BIG;
                    r_res_unused <= r_remain;
                end
            end
        end
        if (i_cmd.alloc_full || i_cmd.unknown) begin
            r_res_status <= i_cmd.unknown ? ST_UNKNOWN_ID : ST_TABLE_FULL;
            r_res_pid    <= i_cmd.unknown ? r_pid : '0;
            r_res_pn     <= '0;
            r_res_left   <= '0;
            r_res_frag   <= r_frag;
            r_res_unused <= r_remain;
        end
        if (i_cmd.place) begin
            r_res_status <= ST_PLACED;
            r_res_pid    <= pcount_p1;
            r_res_pn     <= {1'b0, r_best} + PART_CNT_W'(1);
            r_res_left   <= r_best_left;
            r_res_frag   <= frag_add;
            r_res_unused <= r_remain;
        end
        if (i_cmd.no_fit) begin
            if (r_int) begin
                r_res_status <= ST_INT_FRAG;
            end else if (r_req <= r_frag) begin
                r_res_status <= ST_EXT_FRAG;
            end else begin
                r_res_status <= ST_NO_FIT;
            end
            r_res_pid    <= pcount_p1;
            r_res_pn     <= '0;
            r_res_left   <= '0;
            r_res_frag   <= r_frag;
            r_res_unused <= r_remain;
        end
        if (i_cmd.free_go) begin
            r_res_pid    <= r_pid;
            r_res_unused <= r_remain;
            if ((r_home == '0) || !r_busy[r_idx]) begin
                r_res_status <= ST_NOT_PLACED;
                r_res_pn     <= '0;
                r_res_left   <= '0;
                r_res_frag   <= r_frag;
            end else begin
                r_res_status <= ST_FREED;
                r_res_pn     <= r_home;
                r_res_left   <= lo;
                r_res_frag   <= frag_sub;
            end
        end

        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_pid    <= r_res_pid;
            r_o_pn     <= r_res_pn;
            r_o_left   <= r_res_left;
            r_o_frag   <= r_res_frag;
            r_o_unused <= r_res_unused;
        end
    end

    assign o_status                 = r_o_status;
    assign o_process_id_res         = r_o_pid;
    assign o_partition_number       = r_o_pn;
    assign o_leftover_kb            = r_o_left;
    assign o_fragmentation_total_kb = r_o_frag;
    assign o_unused_kb              = r_o_unused;

endmodule

`default_nettype wire

### rtl/core/fpbf_chk.sv
// Port-level checker of the partition allocator, bound to the top level.
// Depends on fpbf_pkg and the assertion macro header.
`default_nettype none

`include "fixed_partition_best_fit_allocator_macros.svh"

module fpbf_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_valid,
    input wire logic                            o_cfg_ready,
    input wire logic [fpbf_pkg::SIZE_W-1:0]     i_cfg_data,
    input wire logic                            i_valid,
    input wire logic                            o_ready,
    input wire logic [1:0]                      i_op,
    input wire logic [fpbf_pkg::SIZE_W-1:0]     i_size_kb,
    input wire logic [fpbf_pkg::PID_W-1:0]      i_process_id,
    input wire logic                            o_valid,
    input wire logic                            i_ready,
    input wire logic [fpbf_pkg::STATUS_W-1:0]   o_status,
    input wire logic [fpbf_pkg::PID_W-1:0]      o_process_id_res,
    input wire logic [fpbf_pkg::PART_CNT_W-1:0] o_partition_number,
    input wire logic [fpbf_pkg::SIZE_W-1:0]     o_leftover_kb,
    input wire logic [fpbf_pkg::SIZE_W-1:0]     o_fragmentation_total_kb,
    input wire logic [fpbf_pkg::SIZE_W-1:0]     o_unused_kb
);
    import fpbf_pkg::*;

    // a stalled result word must not move
    `FPBF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_leftover_kb))

    // one word in flight: intake closes right after an acceptance
    `FPBF_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)

    // a placement always names its partition and a process number
    `FPBF_ASSERT_NOW(a_placed_ids, o_valid && (o_status == ST_PLACED), (o_partition_number != '0) && (o_process_id_res != '0))

    // failures carry no partition and no leftover
    `FPBF_ASSERT_NOW(a_fail_empty, o_valid && ((o_status == ST_INT_FRAG) || (o_status == ST_EXT_FRAG) || (o_status == ST_NO_FIT) || (o_status == ST_NOT_PLACED) || (o_status == ST_UNKNOWN_ID) || (o_status == ST_TABLE_FULL)), (o_partition_number == '0) && (o_leftover_kb == '0))

endmodule

bind fixed_partition_best_fit_allocator fpbf_chk u_fpbf_chk (.*);

`default_nettype wire
